### hw/rtl/shortest_job_ready_queue_defines.svh
// ----------------------------------------------------------------------------
// shortest_job_ready_queue_defines
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef SHORTEST_JOB_READY_QUEUE_DEFINES_SVH
`define SHORTEST_JOB_READY_QUEUE_DEFINES_SVH

// consequent must hold in the same cycle
`define SJRQ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the next cycle
`define SJRQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/sjrq_pkg.sv
// ----------------------------------------------------------------------------
// sjrq_pkg
// types and codes of the shortest-job ready queue
// ----------------------------------------------------------------------------
package sjrq_pkg;

	localparam int unsigned KEY_W = 16;
	localparam int unsigned ID_W  = 16;
	localparam int unsigned OCC_W = 5;

	typedef enum logic [0:0] {
		OP_INSERT = 1'b0,
		OP_REMOVE = 1'b1
	} sjrq_op_t;

	typedef enum logic [1:0] {
		ST_INSERTED = 2'd0,
		ST_REMOVED  = 2'd1,
		ST_FULL     = 2'd2,
		ST_EMPTY    = 2'd3
	} sjrq_status_t;

	typedef struct packed {
		sjrq_op_t           func;
		logic [KEY_W-1:0]   burst_time;
		logic [ID_W-1:0]    job_id;
	} sjrq_req_t;

	typedef struct packed {
		sjrq_status_t       status;
		logic [KEY_W-1:0]   out_burst_time;
		logic [ID_W-1:0]    out_job_id;
		logic [OCC_W-1:0]   occupancy;
	} sjrq_rsp_t;

	// one stored job
	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [ID_W-1:0]    id;
	} sjrq_entry_t;

	// broadcast from the control to every cell
	typedef struct packed {
		logic               ins;
		logic               rem;
		sjrq_entry_t        job;
	} sjrq_ctl_t;

endpackage

### hw/rtl/sjrq_cell.sv
// ----------------------------------------------------------------------------
// sjrq_cell
// one slot of the sorted array: compares the new key, shifts with neighbors
// ----------------------------------------------------------------------------
module sjrq_cell
	import sjrq_pkg::*;
(
	input  logic        clk,
	input  sjrq_ctl_t   ctl,
	input  logic        occupied,
	input  logic        prev_less,
	input  sjrq_entry_t prev_entry,
	input  sjrq_entry_t next_entry,
	output sjrq_entry_t entry,
	output logic        less
);

	sjrq_entry_t entry_q;

	assign entry = entry_q;
	// stays in place on insert when its key is smaller than the new one
	assign less  = occupied && (entry_q.key < ctl.job.key);

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (!less) begin
				// first slot at or above the new key takes it, later ones shift down
				entry_q <= prev_less ? ctl.job : prev_entry;
			end
		end else if (ctl.rem) begin
			entry_q <= next_entry;
		end
	end

endmodule

### hw/rtl/shortest_job_ready_queue.sv
// ----------------------------------------------------------------------------
// shortest_job_ready_queue
// bounded ready queue sorted by burst time, built as a row of slot cells
// ----------------------------------------------------------------------------
//  channel | signals                    | direction | payload
//  req     | req_valid, req_ready, req  | in        | func, burst_time, job_id
//  rsp     | rsp_valid, rsp_ready, rsp  | out       | status, burst time, id, occupancy
//
//  every cell compares the new key in parallel, so a transaction needs no serial search
//  and one request is taken per cycle while the response register is free or draining
//  response is registered and valid in the cycle after the request transaction
//  a stalled response holds req_ready low; no clearing pass after reset
// ----------------------------------------------------------------------------
module shortest_job_ready_queue
	import sjrq_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  sjrq_req_t req,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output sjrq_rsp_t rsp
);

	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [CNT_W-1:0]         cnt_q;
	logic [CNT_W-1:0]         cnt_nxt;
	logic                     rsp_valid_q;
	sjrq_rsp_t                rsp_q;
	sjrq_rsp_t                rsp_nxt;
	sjrq_ctl_t                ctl;
	sjrq_entry_t              entry [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0]   less;
	logic [QUEUE_DEPTH-1:0]   occupied;
	logic                     accept;
	logic                     full;
	logic                     empty;

	assign req_ready = !rsp_valid_q || rsp_ready;
	assign accept    = req_valid && req_ready;
	assign full      = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign empty     = (cnt_q == '0);

	always_comb begin
		ctl.ins    = accept && (req.func == OP_INSERT) && !full;
		ctl.rem    = accept && (req.func == OP_REMOVE) && !empty;
		ctl.job.key = req.burst_time;
		ctl.job.id  = req.job_id;
	end

	always_comb begin
		cnt_nxt = cnt_q;
		if (ctl.ins) begin
			cnt_nxt = cnt_q + CNT_W'(1);
		end else if (ctl.rem) begin
			cnt_nxt = cnt_q - CNT_W'(1);
		end
	end

	always_comb begin
		rsp_nxt.out_burst_time = '0;
		rsp_nxt.out_job_id     = '0;
		rsp_nxt.occupancy      = OCC_W'(cnt_nxt);
		if (req.func == OP_INSERT) begin
			rsp_nxt.status = full ? ST_FULL : ST_INSERTED;
		end else if (empty) begin
			rsp_nxt.status = ST_EMPTY;
		end else begin
			rsp_nxt.status         = ST_REMOVED;
			rsp_nxt.out_burst_time = entry[0].key;
			rsp_nxt.out_job_id     = entry[0].id;
		end
	end

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic        prev_less;
		sjrq_entry_t prev_entry;
		sjrq_entry_t next_entry;

		assign occupied[i] = (cnt_q > CNT_W'(i));

		if (i == 0) begin : g_head
			assign prev_less  = 1'b1;
			assign prev_entry = entry[i];
		end else begin : g_body
			assign prev_less  = less[i-1];
			assign prev_entry = entry[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign next_entry = entry[i];
		end else begin : g_inner
			assign next_entry = entry[i+1];
		end

		sjrq_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.occupied   (occupied[i]),
			.prev_less  (prev_less),
			.prev_entry (prev_entry),
			.next_entry (next_entry),
			.entry      (entry[i]),
			.less       (less[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			cnt_q <= cnt_nxt;
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_nxt;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

### hw/rtl/sjrq_checker.sv
// ----------------------------------------------------------------------------
// sjrq_checker
// port-level checks on the shortest-job ready queue
// ----------------------------------------------------------------------------
`include "shortest_job_ready_queue_defines.svh"

module sjrq_checker
	import sjrq_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      req_valid,
	input logic      req_ready,
	input logic      rsp_valid,
	input logic      rsp_ready,
	input sjrq_rsp_t rsp
);

	logic req_take;
	logic rsp_stall;
	logic rsp_no_job;

	assign req_take   = req_valid && req_ready;
	assign rsp_stall  = rsp_valid && !rsp_ready;
	assign rsp_no_job = (rsp.out_burst_time == '0) && (rsp.out_job_id == '0);

	// a stalled response holds its value
	`SJRQ_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(rsp), "response changed")

	// each request transaction yields a response next cycle
	`SJRQ_ASSERT_NEXT(a_rsp_follows, req_take, rsp_valid, "no response after request")

	// single response slot: no request taken while it is stuck
	`SJRQ_ASSERT_NOW(a_no_overrun, rsp_stall, !req_ready, "request over stalled response")

	// non-remove results carry no job
	`SJRQ_ASSERT_NOW(a_zero_payload, rsp_valid && (rsp.status != ST_REMOVED), rsp_no_job, "job")

endmodule

bind shortest_job_ready_queue sjrq_checker u_sjrq_checker (.*);

### bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives insert and remove transactions into the shortest-job ready queue
// with random gaps on both channels, keeps a shadow sorted list of the
// stored jobs and checks every response field against it or the typed rows
// ----------------------------------------------------------------------------
module tb_top;
	import sjrq_pkg::*;

	localparam int unsigned DEPTH      = 16;
	localparam int unsigned IDLE_LIMIT = 2000;
	localparam int unsigned N_BATCHES  = 29;
	localparam int unsigned BATCH_LEN  = 50;
	localparam int unsigned N_DIRECTED = 23;

	typedef struct packed {
		sjrq_req_t job;
		logic      typed;
		sjrq_rsp_t rsp;
	} dir_row_t;

	logic      clk;
	logic      arst_n    = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_ready;
	sjrq_req_t req       = '0;
	logic      rsp_valid;
	logic      rsp_ready = 1'b0;
	sjrq_rsp_t rsp;

	// shadow of the sorted list, slot 0 is the head
	logic [KEY_W-1:0] shadow_key [DEPTH];
	logic [ID_W-1:0]  shadow_id  [DEPTH];
	int unsigned      shadow_count = 0;

	sjrq_rsp_t   awaited_rsp [$];
	int unsigned mismatches  = 0;
	int unsigned idle_cycles = 0;
	bit          no_gaps     = 1'b0;
	int unsigned n_inserted  = 0;
	int unsigned n_removed   = 0;
	int unsigned n_full      = 0;
	int unsigned n_empty     = 0;
	int unsigned peak_occ    = 0;

	// directed rows: typed expectation where it is obvious, shadow list otherwise
	dir_row_t dir_table [N_DIRECTED] = '{
		'{'{OP_REMOVE, 16'h1357, 16'h2468}, 1'b1, '{ST_EMPTY, 16'h0, 16'h0, 5'd0}},
		'{'{OP_INSERT, 16'hffff, 16'hffff}, 1'b1, '{ST_INSERTED, 16'h0, 16'h0, 5'd1}},
		'{'{OP_INSERT, 16'h0000, 16'h0000}, 1'b1, '{ST_INSERTED, 16'h0, 16'h0, 5'd2}},
		'{'{OP_INSERT, 16'h8000, 16'h1234}, 1'b0, '0},
		'{'{OP_INSERT, 16'h8000, 16'h5678}, 1'b0, '0},
		'{'{OP_REMOVE, 16'hffff, 16'hffff}, 1'b1, '{ST_REMOVED, 16'h0, 16'h0, 5'd3}},
		'{'{OP_REMOVE, 16'h0000, 16'h0000}, 1'b0, '0},
		'{'{OP_INSERT, 16'hffff, 16'h0001}, 1'b0, '0},
		'{'{OP_INSERT, 16'h0001, 16'haaaa}, 1'b0, '0},
		'{'{OP_INSERT, 16'h7fff, 16'h5555}, 1'b0, '0},
		'{'{OP_INSERT, 16'h0100, 16'h00ff}, 1'b0, '0},
		'{'{OP_INSERT, 16'h00ff, 16'h0100}, 1'b0, '0},
		'{'{OP_INSERT, 16'h0001, 16'hbbbb}, 1'b0, '0},
		'{'{OP_INSERT, 16'h4000, 16'h8001}, 1'b0, '0},
		'{'{OP_INSERT, 16'h0000, 16'hfffe}, 1'b0, '0},
		'{'{OP_INSERT, 16'hc000, 16'h3c3c}, 1'b0, '0},
		'{'{OP_INSERT, 16'h2000, 16'hc3c3}, 1'b0, '0},
		'{'{OP_INSERT, 16'h8000, 16'h0f0f}, 1'b0, '0},
		'{'{OP_INSERT, 16'h1000, 16'hf0f0}, 1'b0, '0},
		'{'{OP_INSERT, 16'hfffe, 16'h7777}, 1'b0, '0},
		'{'{OP_INSERT, 16'h0800, 16'h9999}, 1'b0, '0},
		'{'{OP_INSERT, 16'h0042, 16'h0042}, 1'b1, '{ST_FULL, 16'h0, 16'h0, 5'd16}},
		'{'{OP_REMOVE, 16'h5a5a, 16'ha5a5}, 1'b0, '0}
	};

	shortest_job_ready_queue #(
		.QUEUE_DEPTH(DEPTH)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// applies one transaction to the shadow list and returns the response it earns
	function automatic sjrq_rsp_t sjf_next_rsp(input sjrq_req_t job);
		sjrq_rsp_t   r;
		int unsigned pos;
		r = '0;
		if (job.func == OP_INSERT) begin
			if (shadow_count >= DEPTH) begin
				r.status = ST_FULL;
			end else begin
				pos = 0;
				while (pos < shadow_count && shadow_key[pos] < job.burst_time)
					pos++;
				for (int unsigned i = shadow_count; i > pos; i--) begin
					shadow_key[i] = shadow_key[i-1];
					shadow_id[i]  = shadow_id[i-1];
				end
				shadow_key[pos] = job.burst_time;
				shadow_id[pos]  = job.job_id;
				shadow_count++;
				r.status = ST_INSERTED;
			end
		end else if (shadow_count == 0) begin
			r.status = ST_EMPTY;
		end else begin
			r.status         = ST_REMOVED;
			r.out_burst_time = shadow_key[0];
			r.out_job_id     = shadow_id[0];
			for (int unsigned i = 1; i < shadow_count; i++) begin
				shadow_key[i-1] = shadow_key[i];
				shadow_id[i-1]  = shadow_id[i];
			end
			shadow_count--;
		end
		r.occupancy = OCC_W'(shadow_count);
		return r;
	endfunction

	function automatic sjrq_req_t random_job(input int unsigned ins_pct);
		sjrq_req_t j;
		j.func = ($urandom_range(0, 99) < ins_pct) ? OP_INSERT : OP_REMOVE;
		// narrow keys give plenty of ties
		case ($urandom_range(0, 3))
			0, 1: j.burst_time = KEY_W'($urandom_range(0, 7));
			2: j.burst_time = KEY_W'($urandom_range(0, 65535));
			default: j.burst_time = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
		endcase
		j.job_id = ID_W'($urandom_range(0, 65535));
		return j;
	endfunction

	task automatic send_job(input sjrq_req_t job, input logic typed, input sjrq_rsp_t typed_rsp);
		int unsigned gap;
		sjrq_rsp_t   predicted;
		gap = no_gaps ? 0 : $urandom_range(0, 7);
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req       <= job;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		predicted = sjf_next_rsp(job);
		awaited_rsp.push_back(typed ? typed_rsp : predicted);
	endtask

	// response side stalls
	initial begin
		int unsigned stall;
		@(posedge arst_n);
		forever begin
			stall = no_gaps ? 0 : $urandom_range(0, 7);
			if (stall != 0) begin
				rsp_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			@(posedge clk);
			while (!rsp_valid)
				@(posedge clk);
		end
	end

	always @(posedge clk) begin
		sjrq_rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (awaited_rsp.size() == 0) begin
				$display("%0t: response transaction with none expected, actual %p", $time, rsp);
				mismatches++;
			end else begin
				want = awaited_rsp.pop_front();
				if (rsp.status !== want.status) begin
					$display("%0t: status expected %s actual %0d", $time, want.status.name(),
						rsp.status);
					mismatches++;
				end
				if (rsp.out_burst_time !== want.out_burst_time) begin
					$display("%0t: out_burst_time expected %h actual %h", $time,
						want.out_burst_time, rsp.out_burst_time);
					mismatches++;
				end
				if (rsp.out_job_id !== want.out_job_id) begin
					$display("%0t: out_job_id expected %h actual %h", $time, want.out_job_id,
						rsp.out_job_id);
					mismatches++;
				end
				if (rsp.occupancy !== want.occupancy) begin
					$display("%0t: occupancy expected %0d actual %0d", $time, want.occupancy,
						rsp.occupancy);
					mismatches++;
				end
				case (want.status)
					ST_INSERTED: n_inserted++;
					ST_REMOVED:  n_removed++;
					ST_FULL:     n_full++;
					default:     n_empty++;
				endcase
				if (want.occupancy > peak_occ)
					peak_occ = want.occupancy;
			end
		end
	end

	// watchdog on cycles with no transaction on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
				$display("shortest_job_ready_queue test failed");
				$finish;
			end
		end
	end

	initial begin
		int unsigned ins_pct;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int unsigned n = 0; n < N_DIRECTED; n++)
			send_job(dir_table[n].job, dir_table[n].typed, dir_table[n].rsp);

		// batches lean toward filling or draining so both ends are reached often
		for (int unsigned b = 0; b < N_BATCHES; b++) begin
			case ($urandom_range(0, 4))
				0: ins_pct = 90;
				1: ins_pct = 60;
				2: ins_pct = 50;
				3: ins_pct = 35;
				default: ins_pct = 10;
			endcase
			no_gaps = ($urandom_range(0, 3) == 0);
			for (int unsigned k = 0; k < BATCH_LEN; k++)
				send_job(random_job(ins_pct), 1'b0, '0);
		end
		req_valid <= 1'b0;

		while (awaited_rsp.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("covered %0d inserts, %0d removals, %0d rejected when full,",
			n_inserted, n_removed, n_full);
		$display("%0d removals from empty, peak occupancy %0d of %0d, %0d field mismatches",
			n_empty, peak_occ, DEPTH, mismatches);
		if (mismatches == 0)
			$display("shortest_job_ready_queue test passed");
		else
			$display("shortest_job_ready_queue test failed");
		$finish;
	end

endmodule
